// ===== src/buddy_page_allocator_defines.svh =====
// Assertion macros for the buddy page allocator.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define BPA_ASSERT_IMPL(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define BPA_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/bpa_pkg.sv =====
package bpa_pkg;
   localparam int ORDER_COUNT = 11;
   localparam int POOL_PAGES = 4096;
   localparam int ORD_W = 4;
   localparam int IDX_W = 12;
   localparam int LNK_W = 13;
   localparam int PAGE_W = 52;
   localparam int CNT_W = 13;

   localparam logic [1:0] OP_INIT = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [0:0] CSR_BASE = 1'b0;
   localparam logic [0:0] CSR_TOTAL = 1'b1;

   typedef struct packed {
      logic we;
      logic [IDX_W-1:0] waddr;
      logic [LNK_W-1:0] wdata;
      logic [IDX_W-1:0] raddr;
   } link_req_type;
endpackage

// ===== src/bpa_link_ram.sv =====
module bpa_link_ram (
   input logic clock,
   input bpa_pkg::link_req_type req,
   output logic [bpa_pkg::LNK_W-1:0] rdata
);
   import bpa_pkg::*;
   logic [LNK_W-1:0] mem [POOL_PAGES];

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      rdata <= mem[req.raddr];
   end
endmodule

// ===== src/bpa_engine.sv =====
module bpa_engine (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [1:0] op,
   input logic [bpa_pkg::ORD_W-1:0] ord,
   input logic [bpa_pkg::PAGE_W-1:0] page,
   input logic [bpa_pkg::PAGE_W-1:0] base_page,
   input logic [bpa_pkg::CNT_W-1:0] page_count,
   output logic busy,
   output logic done,
   output logic [1:0] status,
   output logic [bpa_pkg::PAGE_W-1:0] granted,
   output bpa_pkg::link_req_type link_req,
   input logic [bpa_pkg::LNK_W-1:0] link_rdata
);
   import bpa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_ASCAN, S_APOP, S_ASPLIT,
      S_FCHK, S_FSTEP, S_FWAIT, S_FPUSH, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic [LNK_W-1:0] heads_ff [ORDER_COUNT];
   logic [LNK_W-1:0] heads_in [ORDER_COUNT];
   logic [ORD_W-1:0] ord_ff, ord_in, cur_ord_ff, cur_ord_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [IDX_W:0] pos_ff, pos_in;
   logic [IDX_W-1:0] rel_ff, rel_in, blk_ff, blk_in;
   logic [IDX_W-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic prev_head_ff, prev_head_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic [1:0] status_ff, status_in;
   logic [PAGE_W-1:0] granted_ff, granted_in;
   logic done_ff, done_in;
   link_req_type lreq;

   logic [PAGE_W-1:0] off;
   logic [CNT_W-1:0] bsize, lsize;
   logic [IDX_W-1:0] bud;
   logic [PAGE_W:0] off_end;

   assign off = page - base_page;
   assign bsize = CNT_W'(1) << cur_ord_ff;
   assign lsize = CNT_W'(1) << ord;
   assign off_end = {1'b0, off} + (PAGE_W+1)'(lsize);
   assign bud = rel_ff ^ IDX_W'(bsize);

   always_comb begin
      state_in = state_ff;
      heads_in = heads_ff;
      ord_in = ord_ff;
      cur_ord_in = cur_ord_ff;
      left_in = left_ff;
      pos_in = pos_ff;
      rel_in = rel_ff;
      blk_in = blk_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      prev_head_in = prev_head_ff;
      steps_in = steps_ff;
      status_in = status_ff;
      granted_in = granted_ff;
      done_in = 1'b0;
      lreq = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = ST_DONE;
               granted_in = '0;
               ord_in = ord;
               cur_ord_in = ord;
               case (op)
                  OP_INIT: begin
                     for (int i = 0; i < ORDER_COUNT; i++) heads_in[i] = '0;
                     left_in = (page_count > CNT_W'(POOL_PAGES)) ?
                        CNT_W'(POOL_PAGES) : page_count;
                     pos_in = '0;
                     cur_ord_in = ORD_W'(ORDER_COUNT - 1);
                     state_in = S_INIT;
                  end
                  OP_ALLOC: begin
                     if (ord >= ORD_W'(ORDER_COUNT)) begin
                        status_in = ST_FAIL;
                        state_in = S_FIN;
                     end else begin
                        state_in = S_ASCAN;
                     end
                  end
                  OP_FREE: begin
                     if (page == '0) begin
                        state_in = S_FIN;
                     end else if (ord >= ORD_W'(ORDER_COUNT)) begin
                        status_in = ST_FAIL;
                        state_in = S_FIN;
                     end else if (off_end > (PAGE_W+1)'(POOL_PAGES)) begin
                        status_in = ST_RANGE;
                        state_in = S_FIN;
                     end else begin
                        rel_in = off[IDX_W-1:0];
                        state_in = S_FCHK;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_INIT: begin
            if (left_ff >= bsize) begin
               lreq.we = 1'b1;
               lreq.waddr = pos_ff[IDX_W-1:0];
               lreq.wdata = heads_ff[cur_ord_ff];
               heads_in[cur_ord_ff] = {1'b1, pos_ff[IDX_W-1:0]};
               pos_in = pos_ff + (IDX_W+1)'(bsize);
               left_in = left_ff - bsize;
            end else if (cur_ord_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cur_ord_in = cur_ord_ff - 1'b1;
            end
         end
         S_ASCAN: begin
            if (heads_ff[cur_ord_ff][LNK_W-1]) begin
               blk_in = heads_ff[cur_ord_ff][IDX_W-1:0];
               lreq.raddr = heads_ff[cur_ord_ff][IDX_W-1:0];
               state_in = S_APOP;
            end else if (cur_ord_ff == ORD_W'(ORDER_COUNT - 1)) begin
               status_in = ST_FAIL;
               state_in = S_FIN;
            end else begin
               cur_ord_in = cur_ord_ff + 1'b1;
            end
         end
         S_APOP: begin
            heads_in[cur_ord_ff] = link_rdata;
            granted_in = base_page + PAGE_W'(blk_ff);
            state_in = S_ASPLIT;
         end
         S_ASPLIT: begin
            if (cur_ord_ff == ord_ff) begin
               state_in = S_FIN;
            end else begin
               lreq.we = 1'b1;
               lreq.waddr = blk_ff + IDX_W'(bsize >> 1);
               lreq.wdata = heads_ff[cur_ord_ff - 1'b1];
               heads_in[cur_ord_ff - 1'b1] = {1'b1, blk_ff + IDX_W'(bsize >> 1)};
               cur_ord_in = cur_ord_ff - 1'b1;
            end
         end
         S_FCHK: begin
            if (cur_ord_ff == ORD_W'(ORDER_COUNT - 1) ||
                  !heads_ff[cur_ord_ff][LNK_W-1]) begin
               state_in = S_FPUSH;
            end else begin
               cur_in = heads_ff[cur_ord_ff][IDX_W-1:0];
               prev_head_in = 1'b1;
               steps_in = '0;
               state_in = S_FSTEP;
            end
         end
         S_FSTEP: begin
            lreq.raddr = cur_ff;
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            if (cur_ff == bud) begin
               if (prev_head_ff) begin
                  heads_in[cur_ord_ff] = link_rdata;
               end else begin
                  lreq.we = 1'b1;
                  lreq.waddr = prev_ff;
                  lreq.wdata = link_rdata;
               end
               if (bud < rel_ff) rel_in = bud;
               cur_ord_in = cur_ord_ff + 1'b1;
               state_in = S_FCHK;
            end else if (!link_rdata[LNK_W-1] ||
                  steps_ff + 1'b1 >= CNT_W'(POOL_PAGES)) begin
               state_in = S_FPUSH;
            end else begin
               prev_in = cur_ff;
               prev_head_in = 1'b0;
               cur_in = link_rdata[IDX_W-1:0];
               steps_in = steps_ff + 1'b1;
               state_in = S_FSTEP;
            end
         end
         S_FPUSH: begin
            lreq.we = 1'b1;
            lreq.waddr = rel_ff;
            lreq.wdata = heads_ff[cur_ord_ff];
            heads_in[cur_ord_ff] = {1'b1, rel_ff};
            state_in = S_FIN;
         end
         S_FIN: begin
            done_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
         for (int i = 0; i < ORDER_COUNT; i++) heads_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
         heads_ff <= heads_in;
      end
      ord_ff <= ord_in;
      cur_ord_ff <= cur_ord_in;
      left_ff <= left_in;
      pos_ff <= pos_in;
      rel_ff <= rel_in;
      blk_ff <= blk_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      prev_head_ff <= prev_head_in;
      steps_ff <= steps_in;
      status_ff <= status_in;
      granted_ff <= granted_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign done = done_ff;
   assign status = status_ff;
   assign granted = (status_ff == ST_DONE) ? granted_ff : '0;
   assign link_req = lreq;
endmodule

// ===== src/buddy_page_allocator.sv =====
// Buddy page allocator over a pool of up to 4096 pages, eleven block orders.
// The req channel carries one command word: opcode 0 rebuilds the free lists
// from the csr registers, 1 allocates a block of 2^order pages, 2 frees one.
// The rsp channel returns one word per command with a status and, for a
// successful allocation, the granted page frame number.
// One command is in work at a time. Allocate scans the orders upward and then
// splits the block down, init pushes blocks from the largest order down, and
// free walks each list entry by entry in its buddy search through the link
// memory that holds the list successors; it has one write and one read port.
// The csr port writes base_page (index 0) and the pool page count (index 1);
// the user must use it only while the block is idle; the block does not enforce this.
// Reset empties all free lists and clears the csr registers; the link memory
// needs no clearing. req_tready stays low from the end of a command until its
// response word has been taken, so a stalled receiver holds off new commands.
module buddy_page_allocator (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // opcode[1:0], block_order[5:2], block_page[57:6], zero pad [63:58]
   input logic [63:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // status[1:0], granted_page[53:2], zero pad [55:54]
   output logic [55:0] rsp_tdata,
   input logic csr_we,
   input logic [0:0] csr_index,
   input logic [51:0] csr_wdata
);
   import bpa_pkg::*;
   `include "buddy_page_allocator_defines.svh"

   logic [PAGE_W-1:0] base_ff;
   logic [CNT_W-1:0] total_ff;
   logic busy, done, start;
   logic [1:0] status;
   logic [PAGE_W-1:0] granted;
   link_req_type link_req;
   logic [LNK_W-1:0] link_rdata;
   logic rsp_valid_ff;
   logic [55:0] rsp_data_ff;

   assign req_tready = !busy && !rsp_valid_ff && !done;
   assign start = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE: base_ff <= csr_wdata;
               CSR_TOTAL: total_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (done) rsp_data_ff <= {2'b00, granted, status};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   bpa_engine u_engine (
      .clock(clock), .reset(reset), .start(start),
      .op(req_tdata[1:0]), .ord(req_tdata[5:2]), .page(req_tdata[57:6]),
      .base_page(base_ff), .page_count(total_ff),
      .busy(busy), .done(done), .status(status), .granted(granted),
      .link_req(link_req), .link_rdata(link_rdata)
   );

   bpa_link_ram u_link (.clock(clock), .req(link_req), .rdata(link_rdata));

   `BPA_ASSERT_IMPL(a_no_start_busy, clock, reset, start, !busy)
   `BPA_ASSERT_NEXT(a_start_busy, clock, reset, start, busy)
   `BPA_ASSERT_IMPL(a_done_empty, clock, reset, done, !rsp_valid_ff)
endmodule

// ===== sim/tb_buddy_page_allocator.sv =====
`timescale 1ns / 100ps

module tb_buddy_page_allocator;
   import bpa_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam logic [51:0] PAGE_MASK = {52{1'b1}};

   typedef struct {
      logic [1:0] status;
      logic [51:0] granted;
   } alloc_result_type;

   typedef struct {
      logic [51:0] page;
      logic [3:0] order;
   } live_block_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [63:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [55:0] rsp_tdata;
   logic csr_we;
   logic [0:0] csr_index;
   logic [51:0] csr_wdata;

   bit list_valid[ORDER_COUNT];
   int unsigned list_head[ORDER_COUNT];
   bit succ_valid[POOL_PAGES];
   int unsigned succ_idx[POOL_PAGES];
   logic [51:0] pool_base;
   logic [12:0] pool_total;

   alloc_result_type pending_rsp[$];
   live_block_type live_blocks[$];
   int errors;
   int idle_cycles;
   int send_idle_pct;
   int recv_idle_pct;

   buddy_page_allocator dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void pool_push(int unsigned ord, int unsigned rel);
      if (ord < ORDER_COUNT && rel < POOL_PAGES) begin
         succ_valid[rel] = list_valid[ord];
         succ_idx[rel] = list_head[ord];
         list_valid[ord] = 1'b1;
         list_head[ord] = rel;
      end
   endfunction

   function automatic bit pool_unlink(int unsigned ord, int unsigned want);
      bit have;
      int unsigned cur;
      bit at_head;
      int unsigned prev;
      int unsigned steps;
      have = list_valid[ord];
      cur = list_head[ord];
      at_head = 1'b1;
      prev = 0;
      steps = 0;
      while (have && cur < POOL_PAGES && steps < POOL_PAGES) begin
         if (cur == want) begin
            if (at_head) begin
               list_valid[ord] = succ_valid[cur];
               list_head[ord] = succ_idx[cur];
            end else begin
               succ_valid[prev] = succ_valid[cur];
               succ_idx[prev] = succ_idx[cur];
            end
            return 1'b1;
         end
         prev = cur;
         at_head = 1'b0;
         have = succ_valid[cur];
         cur = succ_idx[cur];
         steps++;
      end
      return 1'b0;
   endfunction

   function automatic alloc_result_type pool_predict(logic [1:0] op, logic [3:0] order,
                                                     logic [51:0] page);
      alloc_result_type res;
      int unsigned left;
      int unsigned pos;
      int unsigned i;
      int unsigned blk;
      int unsigned ord;
      int unsigned rel;
      int unsigned bud;
      logic [51:0] off;
      res.status = ST_DONE;
      res.granted = '0;
      ord = order;
      if (op == OP_INIT) begin
         left = (pool_total > POOL_PAGES) ? POOL_PAGES : pool_total;
         pos = 0;
         for (int k = 0; k < ORDER_COUNT; k++) list_valid[k] = 1'b0;
         for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
            while (left >= (1 << k)) begin
               pool_push(k, pos);
               pos += (1 << k);
               left -= (1 << k);
            end
         end
      end else if (op == OP_ALLOC) begin
         if (ord >= ORDER_COUNT) begin
            res.status = ST_FAIL;
         end else begin
            i = ord;
            while (i < ORDER_COUNT && !list_valid[i]) i++;
            if (i >= ORDER_COUNT || list_head[i] >= POOL_PAGES) begin
               res.status = ST_FAIL;
            end else begin
               blk = list_head[i];
               list_valid[i] = succ_valid[blk];
               list_head[i] = succ_idx[blk];
               while (i > ord) begin
                  i--;
                  pool_push(i, blk + (1 << i));
               end
               res.granted = pool_base + 52'(blk);
            end
         end
      end else if (op == OP_FREE) begin
         if (page == '0) begin
            res.status = ST_DONE;
         end else if (ord >= ORDER_COUNT) begin
            res.status = ST_FAIL;
         end else begin
            off = page - pool_base;
            if (off >= POOL_PAGES || 64'(off) + (64'd1 << ord) > POOL_PAGES) begin
               res.status = ST_RANGE;
            end else begin
               rel = 32'(off);
               while (ord < ORDER_COUNT - 1) begin
                  bud = rel ^ (1 << ord);
                  if (!pool_unlink(ord, bud)) break;
                  if (bud < rel) rel = bud;
                  ord++;
               end
               pool_push(ord, rel);
            end
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task automatic send_word(input logic [1:0] op, input logic [3:0] order,
                            input logic [51:0] page);
      alloc_result_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, page, order, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      res = pool_predict(op, order, page);
      pending_rsp.push_back(res);
      if (op == OP_INIT) live_blocks.delete();
      if (op == OP_ALLOC && res.status == ST_DONE) live_blocks.push_back('{res.granted, order});
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [51:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_BASE) pool_base = value;
      else pool_total = value[12:0];
   endtask

   task automatic set_pool(input logic [51:0] base, input logic [12:0] total);
      drain_and_settle();
      write_csr(CSR_BASE, base);
      write_csr(CSR_TOTAL, 52'(total));
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_word(OP_ALLOC, 4'd0, '0);
      set_pool(52'd0, 13'd0);
      send_word(OP_INIT, 4'd0, '0);
      send_word(OP_ALLOC, 4'd0, '0);
      set_pool(52'd0, 13'd4096);
      send_word(OP_INIT, 4'd0, '0);
      for (int k = 0; k < ORDER_COUNT; k++) send_word(OP_ALLOC, 4'(k), '0);
      send_word(OP_ALLOC, 4'd11, '0);
      send_word(OP_ALLOC, 4'd15, '0);
      send_word(OP_FREE, 4'd3, '0);
      send_word(OP_FREE, 4'd15, 52'd8);
      send_word(OP_FREE, 4'd0, PAGE_MASK);
      send_word(OP_FREE, 4'd10, 52'd3072);
      send_word(2'd3, 4'd15, PAGE_MASK);
      while (live_blocks.size() != 0) begin
         send_word(OP_FREE, live_blocks[0].order, live_blocks[0].page);
         live_blocks.pop_front();
      end
      send_word(OP_ALLOC, 4'd10, '0);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [51:0] base, input logic [12:0] total,
                                      input int count);
      int r;
      int pick;
      logic [3:0] ord;
      logic [51:0] page;
      set_pool(base, total);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      send_word(OP_INIT, 4'($urandom), 52'({$urandom, $urandom}));
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 85 && r >= 45 && live_blocks.size() != 0) begin
            pick = $urandom_range(live_blocks.size() - 1);
            send_word(OP_FREE, live_blocks[pick].order, live_blocks[pick].page);
            live_blocks.delete(pick);
         end else if (r >= 85 && r < 90) begin
            ord = 4'($urandom);
            if ($urandom_range(1)) page = 52'({$urandom, $urandom});
            else page = pool_base + 52'($urandom_range(4200));
            send_word(OP_FREE, ord, page);
         end else if (r >= 90 && r < 92) begin
            send_word(OP_INIT, 4'($urandom), 52'({$urandom, $urandom}));
         end else if (r == 92) begin
            send_word(2'd3, 4'($urandom), 52'({$urandom, $urandom}));
         end else if (r == 93 && live_blocks.size() != 0) begin
            pick = $urandom_range(live_blocks.size() - 1);
            send_word(OP_FREE, live_blocks[pick].order, live_blocks[pick].page);
         end else begin
            if ($urandom_range(19) == 0) ord = 4'($urandom);
            else if ($urandom_range(3) == 0) ord = 4'($urandom_range(10));
            else ord = 4'($urandom_range(3));
            send_word(OP_ALLOC, ord, 52'({$urandom, $urandom}));
         end
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type exp_res;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_tdata));
            end else begin
               exp_res = pending_rsp.pop_front();
               if (rsp_tdata[1:0] !== exp_res.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tdata[1:0], exp_res.status));
               if (rsp_tdata[53:2] !== exp_res.granted)
                  report_mismatch($sformatf("granted_page %h, expected %h",
                                            rsp_tdata[53:2], exp_res.granted));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      errors = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pool_base = '0;
      pool_total = '0;
      for (int k = 0; k < ORDER_COUNT; k++) begin
         list_valid[k] = 1'b0;
         list_head[k] = 0;
      end
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      rsp_tready <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_traffic(18, 84, 52'd0, 13'd4096, 380);
      test_random_traffic(84, 18, 52'hF_FFFF_FFFF_F800, 13'($urandom_range(1, 4095)), 380);
      test_random_traffic(0, 0, 52'({$urandom, $urandom}), 13'd4096, 390);
      drain_and_settle();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
